>>> src/chd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants
// Status codes, controller states and the control/status bundles of the
// canonical Huffman decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned CODE_W  = 32;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned TOTAL_W = 9;
    localparam int unsigned HDR_LEN = 8;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_COUNT    = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_UNSORTED = 3'd4,
        ST_INVALID  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE,
        S_SCAN,
        S_EMIT,
        S_FLUSH,
        S_STAT
    } state_t;

    typedef struct packed {
        logic load_byte;   // take input word into datapath
        logic do_byte;     // header or table byte step
        logic bit_start;   // shift next bit into partial code, begin scan
        logic scan_step;   // compare one table entry
        logic park;        // hold the matched symbol as the pending word
        logic emit_sym;    // pending symbol word leaves
        logic sym_end;     // pending symbol closes the results of its byte
        logic emit_stat;   // status word leaves, clear stream state
    } chd_cmd_t;

    typedef struct packed {
        logic in_data;     // current stream position is in the bitstream
        logic active;      // neither finished nor faulted
        logic scan_last;   // last table entry under compare
        logic hit;         // match at current entry
        logic bits_left;   // more bits remain in the held byte
        logic over;        // partial code longer than limit
        logic pend;        // a symbol word waits to leave
    } chd_stat_t;

endpackage : chd_pkg
`default_nettype wire

>>> src/chd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chd_ctrl: decoder controller
// Sequences header and table bytes, bit-by-bit table scans and output words.
// ----------------------------------------------------------------------------
module chd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_fire,
    input  wire logic               last_reg_i,
    input  wire logic               out_free,
    input  wire chd_pkg::chd_stat_t stat,
    output chd_pkg::chd_cmd_t       cmd,
    output logic                    busy
);
    import chd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_BYTE;
                end
            end
            S_BYTE:
            begin
                if (stat.active && stat.in_data)
                begin
                    state_next = S_SCAN;
                end
                else if (last_reg_i)
                begin
                    state_next = S_STAT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = S_EMIT;
                end
                else if (stat.scan_last)
                begin
                    if (stat.bits_left && !stat.over)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_EMIT:
            begin
                if (!stat.pend || out_free)
                begin
                    if (stat.bits_left && stat.active)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!stat.pend || out_free)
                begin
                    if (last_reg_i)
                    begin
                        state_next = S_STAT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_byte = in_fire;
            end
            S_BYTE:
            begin
                cmd.do_byte   = stat.active && !stat.in_data;
                cmd.bit_start = stat.active && stat.in_data;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.bit_start = !stat.hit && stat.scan_last && stat.bits_left
                    && !stat.over;
            end
            S_EMIT:
            begin
                // older pending symbol leaves, the new match takes its place
                cmd.park      = !stat.pend || out_free;
                cmd.emit_sym  = stat.pend && out_free;
                cmd.bit_start = (!stat.pend || out_free) && stat.bits_left && stat.active;
            end
            S_FLUSH:
            begin
                cmd.emit_sym = stat.pend && out_free;
                cmd.sym_end  = 1'b1;
            end
            S_STAT:
            begin
                cmd.emit_stat = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule : chd_ctrl
`default_nettype wire

>>> src/chd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chd_dp: decoder datapath
// Header fields, canonical code table memories, partial code and counters.
// ----------------------------------------------------------------------------
module chd_dp #(
    parameter int unsigned MAX_SYMBOLS     = 256,
    parameter int unsigned MAX_CODE_LENGTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire chd_pkg::chd_cmd_t      cmd,
    input  wire logic [7:0]             in_byte,
    input  wire logic                   in_last,
    output chd_pkg::chd_stat_t          stat,
    output logic                        last_reg_o,
    output logic [7:0]                  sym_o,
    output logic [2:0]                  status_o,
    output logic [31:0]                 count_o,
    output logic                        end_o
);
    import chd_pkg::*;

    localparam int unsigned IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    logic [BYTE_W-1:0]  byte_reg;
    logic               last_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   olen_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [CODE_W-1:0]  run_reg;
    logic [LEN_W-1:0]   plen_prev_reg;
    logic [CODE_W-1:0]  pcode_reg;
    logic [LEN_W:0]     pbits_reg;
    logic [CNT_W-1:0]   prod_reg;
    status_t            fault_reg;
    logic               fin_reg;
    logic [3:0]         bit_reg;
    logic [TOTAL_W-1:0] scan_reg;
    logic [BYTE_W-1:0]  hit_sym_reg;
    logic [BYTE_W-1:0]  pend_sym_reg;
    logic               pend_reg;

    logic [BYTE_W-1:0] sym_mem  [MAX_SYMBOLS];
    logic [LEN_W-1:0]  len_mem  [MAX_SYMBOLS];
    logic [CODE_W-1:0] code_mem [MAX_SYMBOLS];
    logic [BYTE_W-1:0] rd_sym_reg;
    logic [LEN_W-1:0]  rd_len_reg;
    logic [CODE_W-1:0] rd_code_reg;
    logic              rd_ok_reg;

    logic [POS_W-1:0]   rel;
    logic [IDX_W-1:0]   widx;
    logic [TOTAL_W:0]   tbl_end;
    logic               in_data;
    logic [LEN_W-1:0]   d;
    logic [CODE_W-1:0]  run_new;
    logic               hit;
    logic               len_ok;
    logic               len_bad;
    logic               unsorted;
    logic [TOTAL_W-1:0] scan_first;

    assign rel     = pos_reg - POS_W'(HDR_LEN);
    assign widx    = IDX_W'(rel[POS_W-1:1]);
    assign tbl_end = (TOTAL_W+1)'(HDR_LEN) + {total_reg, 1'b0};
    assign in_data = (pos_reg >= POS_W'(HDR_LEN)) && (pos_reg >= tbl_end);
    assign d       = LEN_W'(byte_reg) - plen_prev_reg;
    assign run_new = (widx == '0) ? '0 : ((run_reg + 32'd1) << d[4:0]);
    assign len_bad = (byte_reg == '0) || (byte_reg > BYTE_W'(MAX_CODE_LENGTH));
    assign unsorted = (widx != '0) && (LEN_W'(byte_reg) < plen_prev_reg);
    assign len_ok  = rd_ok_reg && ({1'b0, rd_len_reg} == pbits_reg);
    assign hit     = len_ok && (rd_code_reg == pcode_reg);
    assign scan_first = '0;

    assign stat.in_data   = in_data;
    assign stat.active    = !fin_reg && (fault_reg == ST_OK);
    assign stat.scan_last = (scan_reg == total_reg);
    assign stat.hit       = hit;
    assign stat.bits_left = (bit_reg != 4'd8);
    assign stat.over      = (pbits_reg > (LEN_W+1)'(MAX_CODE_LENGTH));
    assign stat.pend      = pend_reg;
    assign last_reg_o     = last_reg;

    // table memories: write on symbol and length bytes, read one entry per scan cycle
    always_ff @(posedge clk)
    begin
        if (cmd.do_byte && pos_reg >= POS_W'(HDR_LEN))
        begin
            if (!rel[0])
            begin
                sym_mem[widx] <= byte_reg;
            end
            else if (!len_bad && !unsorted)
            begin
                len_mem[widx]  <= byte_reg[LEN_W-1:0];
                code_mem[widx] <= run_new;
            end
        end
        rd_sym_reg  <= sym_mem[IDX_W'(scan_reg)];
        rd_len_reg  <= len_mem[IDX_W'(scan_reg)];
        rd_code_reg <= code_mem[IDX_W'(scan_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (hit)
        begin
            hit_sym_reg <= rd_sym_reg;
        end
        if (cmd.park)
        begin
            pend_sym_reg <= hit_sym_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            olen_reg      <= '0;
            total_reg     <= '0;
            run_reg       <= '0;
            plen_prev_reg <= '0;
            pcode_reg     <= '0;
            pbits_reg     <= '0;
            prod_reg      <= '0;
            fault_reg     <= ST_OK;
            fin_reg       <= 1'b0;
            bit_reg       <= '0;
            scan_reg      <= '0;
            rd_ok_reg     <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            // read data is valid in the cycle after its address steps forward
            rd_ok_reg <= cmd.scan_step && !hit && !stat.scan_last
                && (scan_reg < total_reg);
            if (cmd.park)
            begin
                pend_reg <= 1'b1;
            end
            else if (cmd.emit_sym)
            begin
                pend_reg <= 1'b0;
            end
            if (cmd.load_byte)
            begin
                bit_reg <= '0;
            end
            if (cmd.do_byte)
            begin
                pos_reg <= pos_reg + 1'b1;
                if (pos_reg < POS_W'(4))
                begin
                    olen_reg <= {olen_reg[CNT_W-9:0], byte_reg};
                end
                else if (pos_reg < POS_W'(6))
                begin
                    if (olen_reg != '0 && byte_reg != '0)
                    begin
                        fault_reg <= ST_COUNT;
                    end
                end
                else if (pos_reg == POS_W'(6))
                begin
                    if (olen_reg != '0 && byte_reg > 8'd1)
                    begin
                        fault_reg <= ST_COUNT;
                    end
                    total_reg <= TOTAL_W'(byte_reg[0]);
                end
                else if (pos_reg == POS_W'(7))
                begin
                    total_reg <= {total_reg[0], byte_reg};
                    if (olen_reg == '0)
                    begin
                        fin_reg <= 1'b1;
                    end
                    else if ({total_reg[0], byte_reg} == '0
                        || {total_reg[0], byte_reg} > TOTAL_W'(MAX_SYMBOLS))
                    begin
                        fault_reg <= ST_COUNT;
                    end
                end
                else if (rel[0])
                begin
                    if (len_bad)
                    begin
                        fault_reg <= ST_LENGTH;
                    end
                    else if (unsorted)
                    begin
                        fault_reg <= ST_UNSORTED;
                    end
                    else
                    begin
                        run_reg       <= (d > LEN_W'(31)) ? '0 : run_new;
                        plen_prev_reg <= byte_reg[LEN_W-1:0];
                    end
                end
            end
            // shift one code bit in, restart the table scan
            if (cmd.bit_start)
            begin
                pcode_reg <= {pcode_reg[CODE_W-2:0], byte_reg[bit_reg[2:0]]};
                pbits_reg <= pbits_reg + 1'b1;
                bit_reg   <= bit_reg + 1'b1;
                scan_reg  <= scan_first;
            end
            else if (cmd.scan_step)
            begin
                if (hit)
                begin
                    prod_reg  <= prod_reg + 1'b1;
                    pcode_reg <= '0;
                    pbits_reg <= '0;
                    if (prod_reg + 1'b1 == olen_reg)
                    begin
                        fin_reg <= 1'b1;
                    end
                end
                else if (stat.scan_last && stat.over)
                begin
                    fault_reg <= ST_INVALID;
                end
                else if (!stat.scan_last)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            if (cmd.emit_stat)
            begin
                pos_reg       <= '0;
                olen_reg      <= '0;
                total_reg     <= '0;
                run_reg       <= '0;
                plen_prev_reg <= '0;
                pcode_reg     <= '0;
                pbits_reg     <= '0;
                prod_reg      <= '0;
                fault_reg     <= ST_OK;
                fin_reg       <= 1'b0;
            end
        end
    end

    assign sym_o    = pend_sym_reg;
    assign status_o = (fault_reg != ST_OK) ? fault_reg : (fin_reg ? ST_OK : ST_TRUNC);
    assign count_o  = prod_reg;
    assign end_o    = cmd.sym_end && !last_reg;

endmodule : chd_dp
`default_nettype wire

>>> src/canonical_huffman_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// canonical_huffman_decoder: canonical Huffman stream decoder
// Parses header and code table, then decodes the bitstream one bit at a time.
// ----------------------------------------------------------------------------
// channel  | dir | tdata                       | tuser/tlast
// s_axis   | in  | in_byte[7:0]                | tlast = stream_end
// m_axis   | out | symbol, status, out_count   | tuser = kind, tlast = run_end
//
// Each header or table byte is loaded, then stepped. Each bit of a bitstream
// byte is shifted in and scans the table entries in turn; a match passes the
// emit state, a flush state closes the byte, and a final byte adds a status
// word. A matched symbol waits one match behind so its run end is known;
// output words hold until taken and the controller stalls meanwhile.
// Reset clears all control state; table stores hold no reset value.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder #(
    parameter int unsigned MAX_SYMBOLS     = 256,
    parameter int unsigned MAX_CODE_LENGTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tlast,   // stream_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // symbol[7:0], status[10:8], out_count[42:11]
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast    // run_end
);
    import chd_pkg::*;

    chd_cmd_t  cmd;
    chd_stat_t stat;
    logic      busy;
    logic      in_fire;
    logic      last_reg;
    logic      out_free;
    logic [7:0]  sym;
    logic [2:0]  status;
    logic [31:0] count;
    logic        end_w;

    logic        ov_reg;
    logic [47:0] od_reg;
    logic        ou_reg;
    logic        ol_reg;

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ov_reg || m_axis_tready;

    chd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .last_reg_i (last_reg),
        .out_free   (out_free),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy)
    );

    chd_dp #(
        .MAX_SYMBOLS     (MAX_SYMBOLS),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .stat       (stat),
        .last_reg_o (last_reg),
        .sym_o      (sym),
        .status_o   (status),
        .count_o    (count),
        .end_o      (end_w)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.emit_sym || cmd.emit_stat)
        begin
            ov_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_sym)
        begin
            od_reg <= {5'd0, 32'd0, ST_OK, sym};
            ou_reg <= 1'b0;
            ol_reg <= end_w;
        end
        else if (cmd.emit_stat)
        begin
            od_reg <= {5'd0, count, status, 8'd0};
            ou_reg <= 1'b1;
            ol_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tlast  = ol_reg;

`ifndef ASSERT_OFF
    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready)
        else $error("input taken while busy");
    a_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_sym && cmd.emit_stat))
        else $error("two words emitted at once");
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("status word without run end");
`endif

endmodule : canonical_huffman_decoder
`default_nettype wire
